FILE: sv/fbpa_pkg.sv
package fbpa_pkg;

    // Build defaults
    localparam int MAX_BLOCKS_DEF    = 64;
    localparam int ADDRESS_WIDTH_DEF = 32;

    // Field and register widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int CIDX_W  = 2;

    // Register reset values
    localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd4096;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd32;
    localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;

    // Register indexes on the configuration channel
    localparam logic [CIDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COUNT = 2'd2;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_NOT_ALLOC = 2'd2,
        STAT_NO_FREE   = 2'd3
    } status_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_FREE_DIV,
        ST_FREE_FIN
    } state_t;

endpackage

FILE: sv/fbpa_div.sv
// Restoring divider, one quotient bit per cycle.
module fbpa_div
    import fbpa_pkg::*;
#(
    parameter int AW = ADDRESS_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [AW-1:0]     dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [AW-1:0]     quotient,
    output logic [SIZE_W-1:0] remainder
);

    localparam int CW = $clog2(AW + 1);

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [AW-1:0]     quo_reg;
    logic [AW-1:0]     quo_next;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W:0]   rem_diff;
    logic              rem_ge;

    // One step: shift in the next dividend bit, trial subtract
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[AW-1]};
        rem_diff = rem_sh - {1'b0, divisor};
        rem_ge   = (rem_sh >= {1'b0, divisor});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CW'(AW);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            quo_next  = {quo_reg[AW-2:0], rem_ge};
            rem_next  = rem_ge ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
        end
    end

    // Step counter and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Quotient and partial remainder shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/fbpa_map.sv
// In-use bitmap: one bit per block, one write and one registered read a cycle.
module fbpa_map
    import fbpa_pkg::*;
#(
    parameter int IDXW = $clog2(MAX_BLOCKS_DEF)
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [IDXW-1:0] wr_addr,
    input  logic            wr_data,
    input  logic [IDXW-1:0] rd_addr,
    output logic            rd_data
);

    localparam int DEPTH = 1 << IDXW;

    logic mem_reg [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fixed_block_pool_allocator_unit.sv
// Fixed-block pool allocator with one in-use bit per block. A request is taken
// when start is high and busy is low; its single result shows on status and
// block_address for one cycle with done high, and must be captured then since
// the block cannot be held off. Allocate scans the bitmap one block per cycle
// from index 0 and stops at the first free block, or at the end of the pool
// when it is full. Free runs the offset through the one-bit-per-cycle divider
// that turns it into a block index; a free rejected by the null, base or
// zero-size check answers without running the divider.
// After reset the bitmap is cleared one entry a cycle, with
// busy high. Configuration writes are always taken (cfg_ready is tied high)
// and must only be made while the block is idle; they never touch the bitmap.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
    parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [ADDR_W-1:0]  address,
    output logic               done,
    output logic [1:0]         status,
    output logic [ADDR_W-1:0]  block_address,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]  cfg_data
);

    localparam int AW   = ADDRESS_WIDTH;
    localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNTW = IDXW + 1;

    state_t             state_reg;
    state_t             state_next;

    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [CNTW-1:0]    clr_idx_reg;
    logic [CNTW-1:0]    clr_idx_next;
    logic [CNTW-1:0]    rd_idx_reg;
    logic [CNTW-1:0]    rd_idx_next;
    logic [CNTW-1:0]    chk_idx_reg;
    logic [CNTW-1:0]    chk_idx_next;
    logic               primed_reg;
    logic               primed_next;
    logic [AW-1:0]      acc_reg;
    logic [AW-1:0]      acc_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic               done_reg;
    logic               done_next;
    status_t            status_reg;
    status_t            status_next;
    logic [ADDR_W-1:0]  baddr_reg;
    logic [ADDR_W-1:0]  baddr_next;

    logic [CNTW-1:0]    eff_cnt;
    logic [AW-1:0]      base_aw;
    logic [AW-1:0]      size_aw;
    logic [AW-1:0]      addr_aw;
    logic               scan_end;
    logic               chk_bad;
    logic               div_bad;

    logic               map_wr_en;
    logic [IDXW-1:0]    map_wr_addr;
    logic               map_wr_data;
    logic [IDXW-1:0]    map_rd_addr;
    logic               map_rd_data;

    logic               div_start;
    logic [AW-1:0]      div_dividend;
    logic               div_done;
    logic [AW-1:0]      div_quo;
    logic [SIZE_W-1:0]  div_rem;

    // Bitmap storage
    fbpa_map #(
        .IDXW (IDXW)
    ) u_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    // Offset to block index and remainder
    fbpa_div #(
        .AW (AW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (size_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Effective count and address-width views of the registers
    always_comb
    begin
        if (32'(count_reg) > MAX_BLOCKS)
        begin
            eff_cnt = CNTW'(MAX_BLOCKS);
        end
        else
        begin
            eff_cnt = CNTW'(count_reg);
        end
        base_aw      = AW'(base_reg);
        size_aw      = AW'(size_reg);
        addr_aw      = AW'(addr_reg);
        scan_end     = (chk_idx_reg >= eff_cnt);
        chk_bad      = (addr_aw == '0) || (addr_aw < base_aw) || (size_reg == '0);
        div_bad      = (div_rem != '0) || (div_quo >= AW'(eff_cnt));
        div_dividend = addr_aw - base_aw;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == CNTW'(MAX_BLOCKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (func == FUNC_FREE) ? ST_FREE_CHK : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (primed_reg && (scan_end || !map_rd_data))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE_CHK:
            begin
                state_next = chk_bad ? ST_IDLE : ST_FREE_DIV;
            end
            ST_FREE_DIV:
            begin
                if (div_done)
                begin
                    state_next = div_bad ? ST_IDLE : ST_FREE_FIN;
                end
            end
            ST_FREE_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, bitmap access and result
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        primed_next  = primed_reg;
        acc_next     = acc_reg;
        addr_next    = addr_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        baddr_next   = baddr_reg;
        map_wr_en    = 1'b0;
        map_wr_addr  = chk_idx_reg[IDXW-1:0];
        map_wr_data  = 1'b0;
        map_rd_addr  = (state_reg == ST_SCAN) ? rd_idx_reg[IDXW-1:0] : div_quo[IDXW-1:0];
        div_start    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                map_wr_en    = 1'b1;
                map_wr_addr  = clr_idx_reg[IDXW-1:0];
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next   = address;
                    rd_idx_next = '0;
                    primed_next = 1'b0;
                    acc_next    = base_aw;
                end
            end
            ST_SCAN:
            begin
                // read runs one entry ahead of the check
                rd_idx_next  = rd_idx_reg + 1'b1;
                chk_idx_next = rd_idx_reg;
                primed_next  = 1'b1;
                if (primed_reg)
                begin
                    if (scan_end)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_NO_FREE;
                        baddr_next  = '0;
                    end
                    else if (!map_rd_data)
                    begin
                        map_wr_en   = 1'b1;
                        map_wr_data = 1'b1;
                        done_next   = 1'b1;
                        status_next = STAT_OK;
                        baddr_next  = ADDR_W'(acc_reg);
                    end
                    else
                    begin
                        acc_next = acc_reg + size_aw;
                    end
                end
            end
            ST_FREE_CHK:
            begin
                if (chk_bad)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_INVALID;
                    baddr_next  = '0;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_FREE_DIV:
            begin
                if (div_done && div_bad)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_INVALID;
                    baddr_next  = '0;
                end
            end
            ST_FREE_FIN:
            begin
                done_next  = 1'b1;
                baddr_next = '0;
                if (map_rd_data)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_addr = div_quo[IDXW-1:0];
                    status_next = STAT_OK;
                end
                else
                begin
                    status_next = STAT_NOT_ALLOC;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            primed_reg  <= 1'b0;
            done_reg    <= 1'b0;
            base_reg    <= BASE_RST;
            size_reg    <= SIZE_RST;
            count_reg   <= COUNT_RST;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            primed_reg  <= primed_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE:  base_reg  <= cfg_data;
                    CFG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    default:   base_reg  <= base_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        acc_reg     <= acc_next;
        addr_reg    <= addr_next;
        status_reg  <= status_next;
        baddr_reg   <= baddr_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign status        = status_reg;
    assign block_address = baddr_reg;

endmodule

FILE: sv/fbpa_checker.sv
// Port-level checks on the allocator.
module fbpa_checker
    import fbpa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic [ADDR_W-1:0]  block_address
);

    // An accepted request occupies the block in the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted request");

    // Results never come back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe high in two consecutive cycles");

    // A result never shows in the cycle right after its request
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(start && !busy))
        else $error("result one cycle after a request");

    // Only a successful request may carry an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |-> (block_address == '0))
        else $error("non-zero address on a failed request");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .block_address (block_address)
);

FILE: tb/fixed_block_pool_allocator_unit_test.sv
`timescale 1ns / 100ps

module fixed_block_pool_allocator_unit_test;
    import fbpa_pkg::*;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int POOL_MAX = MAX_BLOCKS_DEF;

    typedef struct packed {
        status_t           st;
        logic [ADDR_W-1:0] addr;
    } answer_t;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               func = FUNC_ALLOC;
    logic [ADDR_W-1:0]  address = '0;
    logic               done;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  block_address;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = CFG_BASE;
    logic [ADDR_W-1:0]  cfg_data = '0;

    // Shadow copy of the pool: registers and in-use map
    logic [ADDR_W-1:0]  pool_base = BASE_RST;
    logic [SIZE_W-1:0]  pool_size = SIZE_RST;
    logic [COUNT_W-1:0] pool_count = COUNT_RST;
    logic               pool_used [POOL_MAX] = '{default: 1'b0};

    answer_t pending_answers [$];
    int      mismatch_count = 0;
    int      requests_sent = 0;
    int      settings_used = 1;
    int      outcome_tally [2][4] = '{default: 0};
    bit      steady_phase = 1'b0;

    fixed_block_pool_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .address       (address),
        .done          (done),
        .status        (status),
        .block_address (block_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Blocks actually reachable: count saturates at the built maximum
    function automatic int eff_blocks();
        return (pool_count > POOL_MAX) ? POOL_MAX : int'(pool_count);
    endfunction

    // Expected answer to one request; updates the shadow map
    function automatic answer_t pool_answer(input logic f, input logic [ADDR_W-1:0] a);
        answer_t           ans;
        int                n;
        bit                found;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] idx;
        ans.st   = STAT_NO_FREE;
        ans.addr = '0;
        n        = eff_blocks();
        found    = 1'b0;
        if (f == FUNC_ALLOC)
        begin
            // lowest free block wins
            for (int i = 0; i < n; i++)
            begin
                if (!found && !pool_used[i])
                begin
                    found        = 1'b1;
                    pool_used[i] = 1'b1;
                    ans.st       = STAT_OK;
                    ans.addr     = pool_base + i * pool_size;
                end
            end
        end
        else
        begin
            ans.st = STAT_INVALID;
            if (a != '0 && a >= pool_base && pool_size != '0)
            begin
                offset = a - pool_base;
                idx    = offset / pool_size;
                if ((offset % pool_size) == '0 && idx < n)
                begin
                    if (!pool_used[idx])
                        ans.st = STAT_NOT_ALLOC;
                    else
                    begin
                        pool_used[idx] = 1'b0;
                        ans.st         = STAT_OK;
                    end
                end
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Result checker: every done pulse is matched against the oldest answer
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result with no request outstanding", block_address, '0);
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.st)
                    report_mismatch("status", ADDR_W'(status), ADDR_W'(want.st));
                if (block_address !== want.addr)
                    report_mismatch("block_address", block_address, want.addr);
            end
        end
    end

    // Issue one request and wait until the block takes it
    task automatic send_request(input logic f, input logic [ADDR_W-1:0] a);
        answer_t ans;
        int      gap;
        int      r;
        func    <= f;
        address <= a;
        if (!start)
            start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ans = pool_answer(f, a);
        pending_answers.push_back(ans);
        requests_sent++;
        outcome_tally[f][ans.st]++;
        // mostly short gaps, now and then a long one
        r = $urandom_range(0, 99);
        if (steady_phase || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 95)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait for every answer and for the block to go idle
    task automatic settle();
        if (start)
            start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Register writes back to back; optionally poke the unused index too
    task automatic config_pool(input logic [ADDR_W-1:0] base_v, input logic [ADDR_W-1:0] size_v,
                               input logic [ADDR_W-1:0] count_v, input bit poke_spare);
        logic [CIDX_W-1:0] reg_sel [4];
        logic [ADDR_W-1:0] reg_val [4];
        int                n_wr;
        reg_sel[0] = CFG_BASE;
        reg_val[0] = base_v;
        reg_sel[1] = CFG_SIZE;
        reg_val[1] = size_v;
        reg_sel[2] = CFG_COUNT;
        reg_val[2] = count_v;
        reg_sel[3] = CFG_SPARE;
        reg_val[3] = $urandom();
        n_wr = poke_spare ? 4 : 3;
        cfg_valid <= 1'b1;
        for (int k = 0; k < n_wr; k++)
        begin
            cfg_index <= reg_sel[k];
            cfg_data  <= reg_val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (reg_sel[k])
                CFG_BASE:  pool_base  = reg_val[k];
                CFG_SIZE:  pool_size  = reg_val[k][SIZE_W-1:0];
                CFG_COUNT: pool_count = reg_val[k][COUNT_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Reset defaults: grants, release, double free, ignored address on allocate
    task automatic test_default_pool();
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
        send_request(FUNC_FREE, pool_base + pool_size);
        send_request(FUNC_FREE, pool_base + pool_size);
        settle();
    endtask

    // Ways a free address can be rejected: null, below base, misaligned, past the pool
    task automatic test_free_checks();
        send_request(FUNC_FREE, '0);
        send_request(FUNC_FREE, pool_base - 1);
        send_request(FUNC_FREE, pool_base + 1);
        send_request(FUNC_FREE, pool_base + POOL_MAX * pool_size);
        send_request(FUNC_FREE, 32'hFFFF_FFFF);
        settle();
    endtask

    // Full pool, then a pool with no blocks at all
    task automatic test_exhaustion_and_empty_pool();
        config_pool(pool_base, pool_size, 2, 1'b0);
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_ALLOC, $urandom());
        settle();
        config_pool(pool_base, pool_size, 0, 1'b0);
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_FREE, pool_base);
        settle();
    endtask

    // Zero block size, count above the maximum, address wrap past 2^32
    task automatic test_zero_size_and_wrap();
        config_pool(pool_base, 0, 100, 1'b0);
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_FREE, pool_base);
        settle();
        config_pool(32'hFFFF_FF00, 16'h0080, 64, 1'b0);
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_FREE, 32'h0000_0080);
        send_request(FUNC_FREE, 32'hFFFF_FF00);
        settle();
    endtask

    // Shrinking the count hides used blocks; growing it exposes them again
    task automatic test_config_keeps_map();
        config_pool(BASE_RST, SIZE_RST, 1, 1'b1);
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_ALLOC, $urandom());
        settle();
        config_pool(BASE_RST, SIZE_RST, 64, 1'b0);
        send_request(FUNC_FREE, pool_base + 2 * pool_size);
        send_request(FUNC_FREE, pool_base + 3 * pool_size);
        settle();
    endtask

    // Random mix: allocates, frees of block addresses, malformed frees
    task automatic random_requests(input int n_req);
        int                pick;
        int                eff;
        int                idx;
        int                probe;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < n_req; k++)
        begin
            pick = $urandom_range(0, 99);
            eff  = eff_blocks();
            a    = $urandom();
            if (pick < 45)
                send_request(FUNC_ALLOC, a);
            else if (pick < 85 && eff > 0 && pool_size != '0)
            begin
                idx = $urandom_range(0, eff - 1);
                // mostly aim at a block that is really in use
                if ($urandom_range(0, 4) != 0)
                    for (probe = 0; probe < eff && !pool_used[idx]; probe++)
                        idx = (idx + 1) % eff;
                send_request(FUNC_FREE, pool_base + idx * pool_size);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: a = '0;
                    1: a = pool_base - $urandom_range(1, 16);
                    2: a = pool_base + $urandom_range(0, eff) * pool_size + $urandom_range(1, 3);
                    3: a = pool_base + ($urandom_range(0, 3) + eff) * pool_size;
                    4: a = 32'hFFFF_FFFF;
                    default: ;
                endcase
                send_request(FUNC_FREE, a);
            end
        end
    endtask

    // Phases of random traffic, each under its own pool setting
    task automatic test_random_traffic();
        logic [ADDR_W-1:0] base_v;
        logic [ADDR_W-1:0] size_v;
        logic [ADDR_W-1:0] count_v;
        logic [ADDR_W-1:0] junk;
        for (int p = 0; p < 16; p++)
        begin
            junk = $urandom();
            case (p)
                0: begin base_v = BASE_RST; size_v = SIZE_RST; count_v = COUNT_RST; end
                1: begin base_v = 1; size_v = 1; count_v = 64; end
                2: begin base_v = 32'hFFFF_FFFF; size_v = 16'hFFFF; count_v = 1; end
                3: begin base_v = 32'hFFF0_0000; size_v = 16'hFFFF; count_v = 127; end
                4: begin base_v = $urandom(); size_v = 0; count_v = 64; end
                5: begin base_v = $urandom_range(1, 32'hFFFF); size_v = 3; count_v = 0; end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: base_v = 1;
                        1: base_v = 32'hFFFF_FFFF;
                        2: base_v = '0;
                        3: base_v = $urandom_range(1, 32'hFFFF);
                        4: base_v = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
                        default: base_v = $urandom();
                    endcase
                    case ($urandom_range(0, 7))
                        0: size_v = 1;
                        1: size_v = 16'hFFFF;
                        2: size_v = 0;
                        3: size_v = 1 << $urandom_range(0, 15);
                        4: size_v = $urandom_range(1, 16'hFFFF);
                        default: size_v = $urandom_range(1, 64);
                    endcase
                    case ($urandom_range(0, 9))
                        0: count_v = 0;
                        1: count_v = 1;
                        2: count_v = 64;
                        3: count_v = $urandom_range(65, 127);
                        default: count_v = $urandom_range(1, 64);
                    endcase
                    // upper data bits beyond the register width are dropped
                    size_v  = {junk[ADDR_W-1:SIZE_W], size_v[SIZE_W-1:0]};
                    count_v = {junk[ADDR_W-1:COUNT_W], count_v[COUNT_W-1:0]};
                end
            endcase
            settle();
            config_pool(base_v, size_v, count_v, p[2]);
            steady_phase = (p % 4 == 3);
            random_requests(120);
        end
        steady_phase = 1'b0;
        settle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // map clear pass after reset
        settle();
        test_default_pool();
        test_free_checks();
        test_exhaustion_and_empty_pool();
        test_zero_size_and_wrap();
        test_config_keeps_map();
        test_random_traffic();
        settle();
        repeat (80) @(posedge clk);
        $display("Ran %0d requests across %0d pool settings, %0d result mismatches",
                 requests_sent, settings_used, mismatch_count);
        $display("Grants %0d, pool full %0d, releases %0d, bad addresses %0d, double frees %0d",
                 outcome_tally[FUNC_ALLOC][STAT_OK], outcome_tally[FUNC_ALLOC][STAT_NO_FREE],
                 outcome_tally[FUNC_FREE][STAT_OK], outcome_tally[FUNC_FREE][STAT_INVALID],
                 outcome_tally[FUNC_FREE][STAT_NOT_ALLOC]);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #15_000_000;
        $display("Timeout waiting on the allocator");
        $display("Some tests failed");
        $finish;
    end

endmodule
